// ----- rtl/mwm_pkg.sv -----
// Shared types and constants for the mecanum wheel mixer with speed limit.
// No dependencies; used by mwm_scale_div and mecanum_wheel_mixer_with_limit_top.
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

  localparam int FRAC_BITS_DEF = 12;    // Q12.12 by default

  localparam int FIELD_W    = 24;       // wheel and velocity fields
  localparam int LIMIT_W    = 23;       // speed limit register width
  localparam int QUO_W      = LIMIT_W;  // limited wheel magnitude never exceeds the limit
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'b1;

  localparam logic signed [FIELD_W-1:0] ROT_SCALE_RST = 24'sd410;
  localparam logic [LIMIT_W-1:0]        MAX_SPEED_RST = 23'd16384;

  // Sideband carried alongside the divider lanes
  typedef struct packed {
    logic                            limited;
    logic [LANES-1:0]                neg;
    logic [LANES-1:0][FIELD_W-1:0]   bypass;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/mwm_scale_div.sv -----
// Four-lane pipelined restoring divider: quotient floor(num / den), one bit per stage.
// Depends on mwm_pkg (QUO_W, LANES, side_t).
`timescale 1ns / 1ps
`default_nettype none

module mwm_scale_div #(
  parameter int MAG_W = 37
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [MAG_W+mwm_pkg::QUO_W-1:0] num [mwm_pkg::LANES],
  input  wire logic [MAG_W-1:0]             den,
  input  wire mwm_pkg::side_t               in_side,
  output logic                              out_valid,
  output logic [mwm_pkg::QUO_W-1:0]         quo [mwm_pkg::LANES],
  output mwm_pkg::side_t                    out_side
);

  localparam int QUO_W = mwm_pkg::QUO_W;
  localparam int NUM_W = MAG_W + QUO_W;
  localparam int LANES = mwm_pkg::LANES;

  // Index 0 is the entry register; index s+1 is the output of bit stage s.
  logic [MAG_W-1:0]      rem [QUO_W+1][LANES];
  logic [QUO_W-1:0]      lq  [QUO_W+1][LANES];  // low numerator bits out, quotient bits in
  logic [MAG_W-1:0]      dv  [QUO_W+1];
  mwm_pkg::side_t        sd  [QUO_W+1];
  logic [QUO_W:0]        vld;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] <= num[l][NUM_W-1:QUO_W];
      lq[0][l]  <= num[l][QUO_W-1:0];
    end
    dv[0] <= den;
    sd[0] <= in_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QUO_W-1:0], in_valid};
    end
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           ge;

      assign trial = {rem[s][l], lq[s][l][QUO_W-1]};
      assign diff  = trial - {1'b0, dv[s]};
      assign ge    = (trial >= {1'b0, dv[s]});

      always_ff @(posedge clk) begin
        rem[s+1][l] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        lq[s+1][l]  <= {lq[s][l][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      sd[s+1] <= sd[s];
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_side  = sd[QUO_W];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = lq[QUO_W][l];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mecanum_wheel_mixer_with_limit_top.sv -----
// Mecanum wheel mixer: chassis command to four wheel speeds with proportional limit.
// Depends on mwm_pkg and mwm_scale_div.
//
//   channel   handshake            payload
//   ------    ---------            -------
//   command   start / busy         vel_forward, vel_sideways, vel_rotation, raw_mode
//   result    done (strobe)        wheel_front_a/b, wheel_rear_a/b, was_limited
//   config    cfg_write            cfg_index, cfg_data
//
// A command is taken on any cycle with start high; busy stays low, one command per cycle.
// Each command gives its result as a one-cycle done strobe after seven
// mixing/limit stages, the divider entry register, 23 divider bit stages and the
// output register. The divider depth follows the 23-bit speed limit.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline always advances.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_mixer_with_limit_top #(
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mwm_pkg::FIELD_W-1:0]       vel_forward,
  input  wire logic [mwm_pkg::FIELD_W-1:0]       vel_sideways,
  input  wire logic [mwm_pkg::FIELD_W-1:0]       vel_rotation,
  input  wire logic                              raw_mode,
  output logic                                   done,
  output logic [mwm_pkg::FIELD_W-1:0]            wheel_front_a,
  output logic [mwm_pkg::FIELD_W-1:0]            wheel_front_b,
  output logic [mwm_pkg::FIELD_W-1:0]            wheel_rear_a,
  output logic [mwm_pkg::FIELD_W-1:0]            wheel_rear_b,
  output logic                                   was_limited,
  input  wire logic                              cfg_write,
  input  wire logic [mwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FIELD_W = mwm_pkg::FIELD_W;
  localparam int LIMIT_W = mwm_pkg::LIMIT_W;
  localparam int QUO_W   = mwm_pkg::QUO_W;
  localparam int LANES   = mwm_pkg::LANES;
  localparam int WGT_W   = FIELD_W + 1;
  localparam int PROD_W  = WGT_W + FIELD_W;
  localparam int P_W     = PROD_W - FRAC_BITS;   // rotation term after truncation
  localparam int MAG_W   = P_W;                  // wheel magnitude
  localparam int W_W     = P_W + 1;              // signed wheel sum
  localparam int NUM_W   = MAG_W + LIMIT_W;
  localparam int UNIT_W  = MAG_W - FRAC_BITS;

  localparam logic signed [WGT_W-1:0]  ONE = WGT_W'(1 << FRAC_BITS);
  localparam logic signed [WGT_W-1:0]  WGT_FRONT_RST = WGT_W'(mwm_pkg::ROT_SCALE_RST) - ONE;
  localparam logic signed [WGT_W-1:0]  WGT_REAR_RST  =
    WGT_W'(0) - WGT_W'(mwm_pkg::ROT_SCALE_RST) - ONE;
  localparam logic [PROD_W-1:0]        BIAS   = PROD_W'((1 << FRAC_BITS) - 1);
  localparam logic [UNIT_W-1:0]        HI_U   = UNIT_W'(((1 << 23) - 1) >> FRAC_BITS);
  localparam logic [UNIT_W-1:0]        LO_U   = UNIT_W'((1 << 23) >> FRAC_BITS);

  // ---------------- configuration ----------------
  logic signed [WGT_W-1:0] wgt_front, wgt_rear;   // scale - 1 and -scale - 1
  logic [LIMIT_W-1:0]      max_speed;
  logic signed [WGT_W-1:0] scale_ext;

  assign scale_ext = WGT_W'($signed(cfg_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      wgt_front <= WGT_FRONT_RST;
      wgt_rear  <= WGT_REAR_RST;
      max_speed <= mwm_pkg::MAX_SPEED_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        mwm_pkg::REG_ROT_SCALE: begin
          wgt_front <= scale_ext - ONE;
          wgt_rear  <= WGT_W'(0) - scale_ext - ONE;
        end
        mwm_pkg::REG_MAX_SPEED: begin
          max_speed <= cfg_data[LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- valid chain ----------------
  logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
  logic div_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
      vld_s2 <= 1'b0;
      vld_s3 <= 1'b0;
      vld_s4 <= 1'b0;
      vld_s5 <= 1'b0;
      vld_s6 <= 1'b0;
      vld_s7 <= 1'b0;
      done   <= 1'b0;
    end else begin
      vld_s1 <= start & ~busy;
      vld_s2 <= vld_s1;
      vld_s3 <= vld_s2;
      vld_s4 <= vld_s3;
      vld_s5 <= vld_s4;
      vld_s6 <= vld_s5;
      vld_s7 <= vld_s6;
      done   <= div_valid;
    end
  end

  // ---------------- S1: input register ----------------
  logic signed [FIELD_W-1:0] fwd_s1, side_s1, rot_s1;
  logic                      raw_s1;

  always_ff @(posedge clk) begin
    fwd_s1  <= $signed(vel_forward);
    side_s1 <= $signed(vel_sideways);
    rot_s1  <= $signed(vel_rotation);
    raw_s1  <= raw_mode;
  end

  // ---------------- S2: rotation products ----------------
  logic signed [PROD_W-1:0]  prod_f_s2, prod_r_s2;
  logic signed [FIELD_W-1:0] fwd_s2, side_s2;
  logic                      raw_s2;

  always_ff @(posedge clk) begin
    prod_f_s2 <= PROD_W'(wgt_front) * PROD_W'(rot_s1);
    prod_r_s2 <= PROD_W'(wgt_rear) * PROD_W'(rot_s1);
    fwd_s2    <= fwd_s1;
    side_s2   <= side_s1;
    raw_s2    <= raw_s1;
  end

  // ---------------- S3: truncate toward zero ----------------
  logic [PROD_W-1:0]         sum_f, sum_r;
  logic signed [P_W-1:0]     pf_s3, pr_s3;
  logic signed [FIELD_W-1:0] fwd_s3, side_s3;
  logic                      raw_s3;

  assign sum_f = prod_f_s2 + (prod_f_s2[PROD_W-1] ? BIAS : '0);
  assign sum_r = prod_r_s2 + (prod_r_s2[PROD_W-1] ? BIAS : '0);

  always_ff @(posedge clk) begin
    pf_s3   <= sum_f[PROD_W-1:FRAC_BITS];
    pr_s3   <= sum_r[PROD_W-1:FRAC_BITS];
    fwd_s3  <= fwd_s2;
    side_s3 <= side_s2;
    raw_s3  <= raw_s2;
  end

  // ---------------- S4: wheel mix ----------------
  logic signed [W_W-1:0] fx, sx, pfx, prx;
  logic signed [W_W-1:0] w_s4 [LANES];
  logic                  raw_s4;

  assign fx  = W_W'(fwd_s3);
  assign sx  = W_W'(side_s3);
  assign pfx = W_W'(pf_s3);
  assign prx = W_W'(pr_s3);

  always_ff @(posedge clk) begin
    w_s4[0] <= pfx - fx - sx;
    w_s4[1] <= pfx + fx - sx;
    w_s4[2] <= prx + fx + sx;
    w_s4[3] <= prx - fx + sx;
    raw_s4  <= raw_s3;
  end

  // ---------------- S5: magnitude and sign ----------------
  logic [MAG_W-1:0]   a_s5 [LANES];
  logic [LANES-1:0]   neg_s5;
  logic [FIELD_W-1:0] wlo_s5 [LANES];
  logic               raw_s5;

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      a_s5[i]   <= w_s4[i][W_W-1] ? MAG_W'(-w_s4[i]) : MAG_W'(w_s4[i]);
      neg_s5[i] <= w_s4[i][W_W-1];
      wlo_s5[i] <= w_s4[i][FIELD_W-1:0];
    end
    raw_s5 <= raw_s4;
  end

  // ---------------- S6: pair maxima, raw result, bypass value ----------------
  logic [UNIT_W-1:0]  units [LANES];
  logic [UNIT_W-1:0]  cap   [LANES];
  logic [UNIT_W-1:0]  usat  [LANES];
  logic [FIELD_W-1:0] rmag  [LANES];
  logic [FIELD_W-1:0] rres  [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      units[i] = a_s5[i][MAG_W-1:FRAC_BITS];
      cap[i]   = neg_s5[i] ? LO_U : HI_U;
      usat[i]  = (units[i] > cap[i]) ? cap[i] : units[i];
      rmag[i]  = FIELD_W'(usat[i]) << FRAC_BITS;
      rres[i]  = neg_s5[i] ? FIELD_W'(0) - rmag[i] : rmag[i];
    end
  end

  logic [MAG_W-1:0]              mx01_s6, mx23_s6;
  logic [MAG_W-1:0]              a_s6 [LANES];
  logic [LANES-1:0]              neg_s6;
  logic [LANES-1:0][FIELD_W-1:0] byp_s6;
  logic                          raw_s6;

  always_ff @(posedge clk) begin
    mx01_s6 <= (a_s5[0] > a_s5[1]) ? a_s5[0] : a_s5[1];
    mx23_s6 <= (a_s5[2] > a_s5[3]) ? a_s5[2] : a_s5[3];
    for (int i = 0; i < LANES; i++) begin
      a_s6[i]   <= a_s5[i];
      byp_s6[i] <= raw_s5 ? rres[i] : wlo_s5[i];
    end
    neg_s6 <= neg_s5;
    raw_s6 <= raw_s5;
  end

  // ---------------- S7: largest magnitude and limit decision ----------------
  logic [MAG_W-1:0] mmax;
  logic [MAG_W-1:0] mx_s7;
  logic [MAG_W-1:0] a_s7 [LANES];
  mwm_pkg::side_t   side_s7;

  assign mmax = (mx01_s6 > mx23_s6) ? mx01_s6 : mx23_s6;

  always_ff @(posedge clk) begin
    mx_s7           <= mmax;
    side_s7.limited <= ~raw_s6 & (mmax > MAG_W'(max_speed));
    side_s7.neg     <= neg_s6;
    side_s7.bypass  <= byp_s6;
    for (int i = 0; i < LANES; i++) begin
      a_s7[i] <= a_s6[i];
    end
  end

  // ---------------- divider: floor(|w| * limit / max) ----------------
  logic [NUM_W-1:0]    num [LANES];
  logic [QUO_W-1:0]    quo [LANES];
  mwm_pkg::side_t      div_side;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      num[i] = NUM_W'(a_s7[i]) * NUM_W'(max_speed);
    end
  end

  mwm_scale_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_s7),
    .num       (num),
    .den       (mx_s7),
    .in_side   (side_s7),
    .out_valid (div_valid),
    .quo       (quo),
    .out_side  (div_side)
  );

  // ---------------- output register ----------------
  logic [FIELD_W-1:0] qx  [LANES];
  logic [FIELD_W-1:0] res [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qx[i]  = FIELD_W'(quo[i]);
      res[i] = div_side.limited ? (div_side.neg[i] ? FIELD_W'(0) - qx[i] : qx[i])
                                : div_side.bypass[i];
    end
  end

  always_ff @(posedge clk) begin
    wheel_front_a <= res[0];
    wheel_front_b <= res[1];
    wheel_rear_a  <= res[2];
    wheel_rear_b  <= res[3];
    was_limited   <= div_side.limited;
  end

endmodule

`default_nettype wire
